[hw/rtl/gsp_pkg.sv]
package gsp_pkg;

    localparam int MUL_W = 32;
    localparam int DIV_N = 64;
    localparam int DIV_D = 32;

    localparam logic signed [31:0] ERROR_LIMIT = 32'sd65536000;
    localparam logic ANGLE_MODE = 1'b0;
    localparam logic [24:0] FULL_TURN = 25'd23592960;
    localparam logic [24:0] HALF_TURN = 25'd11796480;

    localparam logic [2:0] REG_SETPOINT    = 3'd0;
    localparam logic [2:0] REG_PROP_GAIN   = 3'd1;
    localparam logic [2:0] REG_INTEG_GAIN  = 3'd2;
    localparam logic [2:0] REG_DERIV_GAIN  = 3'd3;
    localparam logic [2:0] REG_PROP_RATIO  = 3'd4;
    localparam logic [2:0] REG_INTEG_RATIO = 3'd5;
    localparam logic [2:0] REG_DERIV_RATIO = 3'd6;
    localparam logic [2:0] REG_THRESHOLD   = 3'd7;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

[hw/rtl/gsp_mul.sv]
module gsp_mul (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [gsp_pkg::MUL_W-1:0]       a,
    input  logic [gsp_pkg::MUL_W-1:0]       b,
    output logic [2*gsp_pkg::MUL_W-1:0]     p,
    output gsp_pkg::unit_status_t           status
);
    import gsp_pkg::*;

    localparam int CW = $clog2(MUL_W);

    logic [2*MUL_W-1:0] prod_reg;
    logic [MUL_W-1:0]   a_reg;
    logic [CW-1:0]      cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [MUL_W:0]     upper;

    // shift-add, one multiplier bit per cycle
    assign upper = {1'b0, prod_reg[2*MUL_W-1:MUL_W]} +
                   (prod_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                prod_reg <= {{MUL_W{1'b0}}, b};
                a_reg    <= a;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                prod_reg <= {upper, prod_reg[MUL_W-1:1]};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(MUL_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign p           = prod_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

[hw/rtl/gsp_div.sv]
module gsp_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [gsp_pkg::DIV_N-1:0]   n,
    input  logic [gsp_pkg::DIV_D-1:0]   d,
    output logic [gsp_pkg::DIV_N-1:0]   q,
    output logic [gsp_pkg::DIV_D-1:0]   r,
    output gsp_pkg::unit_status_t       status
);
    import gsp_pkg::*;

    localparam int CW = $clog2(DIV_N);

    logic [DIV_N-1:0] quo_reg;
    logic [DIV_D:0]   rem_reg;
    logic [DIV_D-1:0] d_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_D:0]   sh;
    logic             fits;

    // restoring division, one quotient bit per cycle
    assign sh   = {rem_reg[DIV_D-1:0], quo_reg[DIV_N-1]};
    assign fits = sh >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg  <= n;
                rem_reg  <= '0;
                d_reg    <= d;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? sh - {1'b0, d_reg} : sh;
                quo_reg <= {quo_reg[DIV_N-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DIV_N - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign q           = quo_reg;
    assign r           = rem_reg[DIV_D-1:0];
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

[hw/rtl/gain_scheduled_pid.sv]
// the bit-serial multiplier and divider run one after the other for each request,
// and the blend pair of a gain is skipped when |error| > threshold
// only one item is in flight at a time, a new request is taken after the last
// result has been registered at the output
// reset: asynchronous active low, registers to their reset values, integral and
// previous error cleared, first item only records the error
module gain_scheduled_pid (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] measurement,
    input  logic [15:0]        elapsed_ms,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] drive,
    output logic signed [31:0] clamped_error
);
    import gsp_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_WAIT, S_ERR, S_DONE} state_t;
    typedef enum logic [2:0] {
        ST_WRAP, ST_INTEG, ST_DERIV, ST_GMAX, ST_GMIN, ST_BLMUL, ST_BLDIV, ST_TERM
    } step_t;

    state_t state_reg;
    step_t  step_reg;
    logic [1:0] idx_reg;

    logic signed [31:0] setpoint_reg;
    logic [31:0] gain_reg [3];
    logic [15:0] ratio_reg [3];
    logic [30:0] thr_reg;

    logic signed [31:0] integral_reg, last_reg, err_reg, integ_reg, de_reg;
    logic               started_reg;
    logic signed [32:0] diff_reg;
    logic [15:0]        dt_reg;
    logic [31:0]        kmax_reg [3];
    logic [31:0]        kmin_reg [3];
    logic [31:0]        k_reg [3];
    logic signed [67:0] acc_reg;

    logic               out_valid_reg;
    logic signed [31:0] drive_reg, cerr_reg;

    logic [31:0]          mul_a, mul_b;
    logic [63:0]          mul_p;
    logic                 mul_start;
    unit_status_t         mul_st;
    logic [63:0]          div_n, div_q;
    logic [31:0]          div_d, div_r;
    logic                 div_start;
    unit_status_t         div_st;

    logic        is_mul, unit_done;
    logic [31:0] abs_e, gain_sel, mx_sel, mn_sel, vabs;
    logic [15:0] ratio_eff;
    logic [30:0] thr_eff;
    logic        a_over, vneg;
    logic signed [31:0] v_sel;
    logic [32:0] diff_abs, nd_abs;
    logic signed [32:0] nd, wrap_val;
    logic signed [49:0] integ_sum, de_wide;
    logic signed [31:0] integ_new, de_new, err_new;
    logic [31:0] gmax_val;
    logic signed [65:0] term;
    logic signed [51:0] sum_sh;
    logic signed [31:0] drive_sat;

    function automatic logic signed [31:0] clamp_err(input logic signed [49:0] x);
        logic signed [49:0] lim;
        lim = 50'(ERROR_LIMIT);
        if (x > lim)
            return ERROR_LIMIT;
        else if (x < -lim)
            return -ERROR_LIMIT;
        else
            return x[31:0];
    endfunction

    gsp_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .p      (mul_p),
        .status (mul_st)
    );

    gsp_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .n      (div_n),
        .d      (div_d),
        .q      (div_q),
        .r      (div_r),
        .status (div_st)
    );

    always_comb
    begin
        abs_e     = err_reg[31] ? 32'(-err_reg) : 32'(err_reg);
        gain_sel  = gain_reg[idx_reg];
        ratio_eff = (ratio_reg[idx_reg] < 16'd256) ? 16'd256 : ratio_reg[idx_reg];
        thr_eff   = (thr_reg == '0) ? 31'd1 : thr_reg;
        a_over    = abs_e > {1'b0, thr_eff};
        mx_sel    = kmax_reg[idx_reg];
        mn_sel    = kmin_reg[idx_reg];
        case (idx_reg)
            2'd0:    v_sel = err_reg;
            2'd1:    v_sel = integ_reg;
            default: v_sel = de_reg;
        endcase
        vneg      = v_sel[31];
        vabs      = vneg ? 32'(-v_sel) : 32'(v_sel);
        diff_abs  = diff_reg[32] ? 33'(-diff_reg) : 33'(diff_reg);
        nd        = 33'(err_reg) - 33'(last_reg);
        nd_abs    = nd[32] ? 33'(-nd) : 33'(nd);

        is_mul = (step_reg == ST_INTEG) || (step_reg == ST_GMAX) ||
                 (step_reg == ST_BLMUL) || (step_reg == ST_TERM);
        unit_done = is_mul ? mul_st.done : div_st.done;

        mul_a = abs_e;
        mul_b = {16'b0, dt_reg};
        div_n = {31'b0, diff_abs};
        div_d = {7'b0, FULL_TURN};
        case (step_reg)
            ST_GMAX:
            begin
                mul_a = gain_sel;
                mul_b = {16'b0, ratio_eff};
            end
            ST_BLMUL:
            begin
                mul_a = mx_sel - mn_sel;
                mul_b = abs_e;
            end
            ST_TERM:
            begin
                mul_a = k_reg[idx_reg];
                mul_b = vabs;
            end
            ST_DERIV:
            begin
                div_n = {31'b0, nd_abs};
                div_d = {16'b0, dt_reg};
            end
            ST_GMIN:
            begin
                div_n = {24'b0, gain_sel, 8'b0};
                div_d = {16'b0, ratio_eff};
            end
            ST_BLDIV:
            begin
                div_n = mul_p;
                div_d = {1'b0, thr_eff};
            end
            default:
            begin
            end
        endcase
        mul_start = (state_reg == S_ISSUE) && is_mul;
        div_start = (state_reg == S_ISSUE) && !is_mul;

        // floored modulo of a full turn, then into the half-open half turn
        wrap_val = {8'b0, div_r[24:0]};
        if (diff_reg[32] && (div_r[24:0] != '0))
            wrap_val = 33'({8'b0, FULL_TURN}) - wrap_val;
        if (wrap_val > 33'({8'b0, HALF_TURN}))
            wrap_val = wrap_val - 33'({8'b0, FULL_TURN});

        err_new   = clamp_err(50'(diff_reg));
        integ_sum = 50'(integral_reg) +
                    (err_reg[31] ? -50'({2'b0, mul_p[47:0]}) : 50'({2'b0, mul_p[47:0]}));
        integ_new = clamp_err(integ_sum);
        de_wide   = nd[32] ? -50'({17'b0, div_q[32:0]}) : 50'({17'b0, div_q[32:0]});
        de_new    = clamp_err(de_wide);
        gmax_val  = (mul_p[63:40] != '0) ? 32'hFFFF_FFFF : mul_p[39:8];
        term      = vneg ? -66'({2'b0, mul_p}) : 66'({2'b0, mul_p});

        sum_sh = 52'(acc_reg >>> 16);
        if (sum_sh > 52'sd2147483647)
            drive_sat = 32'sh7FFF_FFFF;
        else if (sum_sh < -52'sd2147483648)
            drive_sat = 32'sh8000_0000;
        else
            drive_sat = sum_sh[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg  <= '0;
            gain_reg[0]   <= 32'd65536;
            gain_reg[1]   <= 32'd65536;
            gain_reg[2]   <= 32'd65536;
            ratio_reg[0]  <= 16'd256;
            ratio_reg[1]  <= 16'd256;
            ratio_reg[2]  <= 16'd256;
            thr_reg       <= 31'd65536;
            integral_reg  <= '0;
            last_reg      <= '0;
            started_reg   <= 1'b0;
            state_reg     <= S_IDLE;
            step_reg      <= ST_WRAP;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_SETPOINT:    setpoint_reg <= cfg_data;
                    REG_PROP_GAIN:   gain_reg[0]  <= cfg_data;
                    REG_INTEG_GAIN:  gain_reg[1]  <= cfg_data;
                    REG_DERIV_GAIN:  gain_reg[2]  <= cfg_data;
                    REG_PROP_RATIO:  ratio_reg[0] <= cfg_data[15:0];
                    REG_INTEG_RATIO: ratio_reg[1] <= cfg_data[15:0];
                    REG_DERIV_RATIO: ratio_reg[2] <= cfg_data[15:0];
                    REG_THRESHOLD:   thr_reg      <= cfg_data[30:0];
                endcase
            end

            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        diff_reg <= 33'(setpoint_reg) - 33'(measurement);
                        dt_reg   <= (elapsed_ms == '0) ? 16'd1 : elapsed_ms;
                        step_reg <= ST_WRAP;
                        idx_reg  <= '0;
                        acc_reg  <= '0;
                        state_reg <= ANGLE_MODE ? S_ISSUE : S_ERR;
                    end
                end
                S_ISSUE:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (unit_done)
                    begin
                        state_reg <= S_ISSUE;
                        unique case (step_reg)
                            ST_WRAP:
                            begin
                                diff_reg  <= wrap_val;
                                state_reg <= S_ERR;
                            end
                            ST_INTEG:
                            begin
                                integral_reg <= integ_new;
                                integ_reg    <= integ_new;
                                step_reg     <= ST_DERIV;
                            end
                            ST_DERIV:
                            begin
                                de_reg   <= de_new;
                                last_reg <= err_reg;
                                step_reg <= ST_GMAX;
                            end
                            ST_GMAX:
                            begin
                                kmax_reg[idx_reg] <= gmax_val;
                                step_reg          <= ST_GMIN;
                            end
                            ST_GMIN:
                            begin
                                kmin_reg[idx_reg] <= div_q[31:0];
                                if (a_over)
                                begin
                                    k_reg[idx_reg] <= (idx_reg == 2'd2) ? div_q[31:0] : mx_sel;
                                    idx_reg  <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                                    step_reg <= (idx_reg == 2'd2) ? ST_TERM : ST_GMAX;
                                end
                                else
                                    step_reg <= ST_BLMUL;
                            end
                            ST_BLMUL:
                            begin
                                step_reg <= ST_BLDIV;
                            end
                            ST_BLDIV:
                            begin
                                k_reg[idx_reg] <= (idx_reg == 2'd2) ? mx_sel - div_q[31:0]
                                                                    : mn_sel + div_q[31:0];
                                idx_reg  <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                                step_reg <= (idx_reg == 2'd2) ? ST_TERM : ST_GMAX;
                            end
                            ST_TERM:
                            begin
                                acc_reg <= acc_reg + 68'(term);
                                idx_reg <= idx_reg + 2'd1;
                                if (idx_reg == 2'd2)
                                    state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_ERR:
                begin
                    err_reg <= err_new;
                    if (!started_reg)
                    begin
                        started_reg <= 1'b1;
                        last_reg    <= err_new;
                        state_reg   <= S_DONE;
                    end
                    else
                    begin
                        step_reg  <= ST_INTEG;
                        state_reg <= S_ISSUE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        drive_reg     <= drive_sat;
                        cerr_reg      <= err_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready     = 1'b1;
    assign in_stall      = state_reg != S_IDLE;
    assign out_valid     = out_valid_reg;
    assign drive         = drive_reg;
    assign clamped_error = cerr_reg;

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_st.busy && div_st.busy))
        else $error("multiplier and divider busy together");

    a_request_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second request taken while an item is in flight");

    a_started_holds: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |=> started_reg)
        else $error("started flag cleared outside reset");

    a_integral_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (integral_reg <= ERROR_LIMIT) && (integral_reg >= -ERROR_LIMIT))
        else $error("integral outside error limit");

endmodule
